[design/cje_pkg.sv]
// Shared constants and types of the classical Jacobi eigen solver.
package cje_pkg;

  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned LIM_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned OPND_W    = 34;
  localparam int unsigned PROD_W    = 2 * OPND_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned DIV_W     = 34;

  localparam int unsigned N_DEFAULT    = 4;
  localparam int unsigned FRAC_DEFAULT = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_USED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;

  localparam logic [IDX_W-1:0] SIZE_RESET = 3'd4;
  localparam logic [TOL_W-1:0] TOL_RESET  = 31'd17;
  localparam logic [LIM_W-1:0] LIM_RESET  = 5'd20;

  typedef enum logic {
    UNIT_SQRT = 1'b0,
    UNIT_DIV  = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

endpackage

[design/classical_jacobi_eigen.sv]
// Top level of the classical Jacobi eigen solver with its sequencer and shared multiplier.
//
//   channel   direction  handshake                    payload
//   load      in         start_i high, busy_o low     row_i col_i value_i final_element_i
//   result    out        result_strobe_o, one cycle   kind_o pair_index_o component_o
//                                                     result_value_o converged_o last_result_o
//   config    in         cfg_valid_i and cfg_ready_o  cfg_index_i cfg_data_i
//
// A non-final element is taken while idle. A final element starts a run: the sequencer sets up
// the vector store, then each rotation searches the pivot and uses the shared square root and
// division unit (three roots of 32 steps, one division of 64 steps), and the run ends with
// n(n+1) results.
// Reset clears the sequencer and loads the register defaults; the matrix store is undefined
// until written. Results cannot be stalled by the receiver.
module classical_jacobi_eigen
  import cje_pkg::*;
#(
  parameter int unsigned N         = N_DEFAULT,
  parameter int unsigned FRAC_BITS = FRAC_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     final_element_i,
  output logic                     result_strobe_o,
  output logic                     kind_o,
  output logic [IDX_W-1:0]         pair_index_o,
  output logic [IDX_W-1:0]         component_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     converged_o,
  output logic                     last_result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(N * N);
  localparam logic [WIDE_W-1:0] ONE = WIDE_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE_D = DATA_W'(ONE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_INIT   = 11'b000_0000_0010,
    S_SEARCH = 11'b000_0000_0100,
    S_LOAD   = 11'b000_0000_1000,
    S_RAD    = 11'b000_0001_0000,
    S_UNIT   = 11'b000_0010_0000,
    S_MAC    = 11'b000_0100_0000,
    S_RDX    = 11'b000_1000_0000,
    S_RDY    = 11'b001_0000_0000,
    S_CHECK  = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    J_RADIUS, J_ALFA, J_COS, J_SIN, J_CC, J_SS, J_SC, J_LL, J_KK, J_LK, J_WL, J_WK
  } job_e;

  function automatic logic [AW-1:0] lin_addr(input logic [IDX_W-1:0] a,
                                             input logic [IDX_W-1:0] b);
    return AW'(32'(a) * N + 32'(b));
  endfunction

  function automatic logic [AW-1:0] sym_addr(input logic [IDX_W-1:0] a,
                                             input logic [IDX_W-1:0] b);
    return (a > b) ? lin_addr(a, b) : lin_addr(b, a);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[DATA_W-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] term_count(input job_e j);
    logic [1:0] r;
    unique case (j)
      J_LL, J_KK:       r = 2'd3;
      J_LK, J_WL, J_WK: r = 2'd2;
      default:          r = 2'd1;
    endcase
    return r;
  endfunction

  logic signed [DATA_W-1:0] mat_q [N*N];
  logic signed [DATA_W-1:0] vec_q [N*N];

  logic [IDX_W-1:0] size_q;
  logic [TOL_W-1:0] tol_q;
  logic [LIM_W-1:0] lim_q;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic [1:0] ph_q, ph_d;
  logic [IDX_W-1:0] si_q, si_d, sj_q, sj_d, i_q, i_d, l_q, l_d, k_q, k_d, oi_q, oi_d, oj_q, oj_d;
  logic vmode_q, vmode_d;
  logic [DATA_W:0] best_q, best_d;
  logic [LIM_W-1:0] iter_q, iter_d;
  logic conv_q, conv_d;

  logic signed [DATA_W-1:0] all_q, all_d, akk_q, akk_d, p_q, p_d;
  logic signed [DATA_W-1:0] c_q, c_d, s_q, s_d, nll_q, nll_d, nkk_q, nkk_d, x_q, x_d, y_q, y_d;
  logic signed [DATA_W:0]   cc_q, cc_d, ss_q, ss_d, sc_q, sc_d;
  logic [WIDE_W-1:0]        rad_q, rad_d;
  logic [FRAC_BITS:0]       alfa_q, alfa_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     sub_q;

  logic strobe_q, strobe_d, kind_q, kind_d, last_q, last_d;
  logic [IDX_W-1:0] pair_q, pair_d, comp_q, comp_d;
  logic signed [DATA_W-1:0] rval_q, rval_d;

  logic [IDX_W-1:0] n_eff;
  logic mat_we, vec_we;
  logic [AW-1:0] mat_wa, vec_wa, mat_ra, vec_ra;
  logic signed [DATA_W-1:0] mat_wd, vec_wd, mat_rd, vec_rd;

  logic signed [DATA_W:0]   d_val;
  logic [DATA_W:0]          ud;
  logic [DATA_W-1:0]        up;
  logic                     neg;
  logic signed [OPND_W-1:0] twosc, ccss, neg_s, mul_a, mul_b;
  logic                     term_sub;
  logic signed [PROD_W-1:0] scaled;
  logic signed [ACC_W-1:0]  acc_base, acc_sum;
  logic signed [DATA_W-1:0] acc_sat;
  logic [DATA_W:0]          m_abs, dif_l, dif_k, dif;
  logic signed [DATA_W:0]   dl, dk;
  logic [WIDE_W-1:0]        alfa_v;

  unit_req_t         unit_req;
  logic [WIDE_W-1:0] unit_opa, unit_res;
  logic [DIV_W-1:0]  unit_div;
  logic              unit_done;

  cje_divsqrt u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (unit_req),
    .opa_i     (unit_opa),
    .divisor_i (unit_div),
    .done_o    (unit_done),
    .result_o  (unit_res)
  );

  assign n_eff  = (size_q < IDX_W'(2)) ? IDX_W'(2) : ((size_q > LAST_IDX + IDX_W'(1)) ?
                  LAST_IDX + IDX_W'(1) : size_q);
  assign mat_rd = mat_q[mat_ra];
  assign vec_rd = vec_q[vec_ra];

  assign d_val = (DATA_W + 1)'(all_q) - (DATA_W + 1)'(akk_q);
  assign ud    = d_val[DATA_W] ? -d_val : d_val;
  assign up    = p_q[DATA_W-1] ? -p_q : p_q;
  assign neg   = (d_val == '0) ? p_q[DATA_W-1] : ((d_val > 0) != (p_q > 0));
  assign twosc = OPND_W'(sc_q) <<< 1;
  assign ccss  = OPND_W'(cc_q) - OPND_W'(ss_q);
  assign neg_s = -(OPND_W'(s_q));

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    term_sub = 1'b0;
    if (state_q == S_RAD) begin
      mul_a = (ph_q == 2'd0) ? $signed(OPND_W'(ud)) : $signed(OPND_W'(up));
      mul_b = mul_a;
    end else begin
      unique case (job_q)
        J_CC: begin
          mul_a = OPND_W'(c_q);
          mul_b = OPND_W'(c_q);
        end
        J_SS: begin
          mul_a = OPND_W'(s_q);
          mul_b = OPND_W'(s_q);
        end
        J_SC: begin
          mul_a = OPND_W'(s_q);
          mul_b = OPND_W'(c_q);
        end
        J_LL: begin
          if (ph_q == 2'd0) begin
            mul_a = OPND_W'(cc_q);
            mul_b = OPND_W'(all_q);
          end else if (ph_q == 2'd1) begin
            mul_a = OPND_W'(ss_q);
            mul_b = OPND_W'(akk_q);
          end else begin
            mul_a = twosc;
            mul_b = OPND_W'(p_q);
          end
        end
        J_KK: begin
          if (ph_q == 2'd0) begin
            mul_a = OPND_W'(ss_q);
            mul_b = OPND_W'(all_q);
          end else if (ph_q == 2'd1) begin
            mul_a = OPND_W'(cc_q);
            mul_b = OPND_W'(akk_q);
          end else begin
            mul_a    = twosc;
            mul_b    = OPND_W'(p_q);
            term_sub = 1'b1;
          end
        end
        J_LK: begin
          if (ph_q == 2'd0) begin
            mul_a    = OPND_W'(sc_q);
            mul_b    = OPND_W'(d_val);
            term_sub = 1'b1;
          end else begin
            mul_a = ccss;
            mul_b = OPND_W'(p_q);
          end
        end
        J_WL: begin
          mul_a = (ph_q == 2'd0) ? OPND_W'(c_q) : OPND_W'(s_q);
          mul_b = (ph_q == 2'd0) ? OPND_W'(x_q) : OPND_W'(y_q);
        end
        J_WK: begin
          mul_a = (ph_q == 2'd0) ? neg_s : OPND_W'(c_q);
          mul_b = (ph_q == 2'd0) ? OPND_W'(x_q) : OPND_W'(y_q);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod_d   = mul_a * mul_b;
  assign scaled   = prod_q >>> FRAC_BITS;
  assign acc_base = (ph_q == 2'd1) ? '0 : acc_q;
  assign acc_sum  = sub_q ? (acc_base - ACC_W'(scaled)) : (acc_base + ACC_W'(scaled));
  assign acc_sat  = sat32(acc_sum);

  assign dl    = (DATA_W + 1)'(all_q) - (DATA_W + 1)'(nll_q);
  assign dk    = (DATA_W + 1)'(akk_q) - (DATA_W + 1)'(nkk_q);
  assign dif_l = dl[DATA_W] ? -dl : dl;
  assign dif_k = dk[DATA_W] ? -dk : dk;
  assign dif   = (dif_l > dif_k) ? dif_l : dif_k;
  assign m_abs = mat_rd[DATA_W-1] ? -(DATA_W + 1)'(mat_rd) : (DATA_W + 1)'(mat_rd);
  assign alfa_v = (unit_res > ONE) ? ONE : unit_res;

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    ph_d     = ph_q;
    si_d     = si_q;
    sj_d     = sj_q;
    i_d      = i_q;
    l_d      = l_q;
    k_d      = k_q;
    oi_d     = oi_q;
    oj_d     = oj_q;
    vmode_d  = vmode_q;
    best_d   = best_q;
    iter_d   = iter_q;
    conv_d   = conv_q;
    all_d    = all_q;
    akk_d    = akk_q;
    p_d      = p_q;
    c_d      = c_q;
    s_d      = s_q;
    cc_d     = cc_q;
    ss_d     = ss_q;
    sc_d     = sc_q;
    nll_d    = nll_q;
    nkk_d    = nkk_q;
    x_d      = x_q;
    y_d      = y_q;
    rad_d    = rad_q;
    alfa_d   = alfa_q;
    acc_d    = acc_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    pair_d   = pair_q;
    comp_d   = comp_q;
    rval_d   = rval_q;
    last_d   = last_q;
    mat_we   = 1'b0;
    mat_wa   = '0;
    mat_wd   = value_i;
    vec_we   = 1'b0;
    vec_wa   = '0;
    vec_wd   = '0;
    mat_ra   = '0;
    vec_ra   = '0;
    unit_req = '{start: 1'b0, op: UNIT_SQRT};
    unit_opa = rad_q;
    unit_div = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (row_i < n_eff && col_i < n_eff) begin
            mat_we = 1'b1;
            mat_wa = sym_addr(row_i, col_i);
            mat_wd = value_i;
          end
          if (final_element_i) begin
            si_d    = '0;
            sj_d    = '0;
            conv_d  = 1'b0;
            state_d = S_INIT;
          end
        end
      end

      S_INIT: begin
        vec_we = 1'b1;
        vec_wa = lin_addr(si_q, sj_q);
        vec_wd = (si_q == sj_q) ? ONE_D : '0;
        if (sj_q == LAST_IDX) begin
          sj_d = '0;
          if (si_q == LAST_IDX) begin
            iter_d  = '0;
            si_d    = IDX_W'(1);
            best_d  = '0;
            l_d     = '0;
            k_d     = '0;
            state_d = S_SEARCH;
          end else begin
            si_d = si_q + IDX_W'(1);
          end
        end else begin
          sj_d = sj_q + IDX_W'(1);
        end
      end

      S_SEARCH: begin
        mat_ra = lin_addr(si_q, sj_q);
        if (m_abs > best_q) begin
          best_d = m_abs;
          l_d    = si_q;
          k_d    = sj_q;
        end
        if (sj_q + IDX_W'(1) >= si_q) begin
          sj_d = '0;
          si_d = si_q + IDX_W'(1);
          if (si_q + IDX_W'(1) >= n_eff) begin
            if (best_d == '0) begin
              conv_d  = 1'b1;
              oi_d    = '0;
              oj_d    = '0;
              state_d = S_OUT;
            end else begin
              ph_d    = '0;
              state_d = S_LOAD;
            end
          end
        end else begin
          sj_d = sj_q + IDX_W'(1);
        end
      end

      S_LOAD: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd0) begin
          mat_ra = lin_addr(l_q, l_q);
          all_d  = mat_rd;
        end else if (ph_q == 2'd1) begin
          mat_ra = lin_addr(k_q, k_q);
          akk_d  = mat_rd;
        end else begin
          mat_ra  = lin_addr(l_q, k_q);
          p_d     = mat_rd;
          ph_d    = '0;
          state_d = S_RAD;
        end
      end

      S_RAD: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          rad_d = prod_q[WIDE_W+1:2];
        end else if (ph_q == 2'd2) begin
          rad_d    = rad_q + prod_q[WIDE_W-1:0];
          unit_req = '{start: 1'b1, op: UNIT_SQRT};
          unit_opa = rad_d;
          job_d    = J_RADIUS;
          ph_d     = '0;
          state_d  = S_UNIT;
        end
      end

      S_UNIT: begin
        if (unit_done) begin
          unique case (job_q)
            J_RADIUS: begin
              unit_req = '{start: 1'b1, op: UNIT_DIV};
              unit_opa = WIDE_W'(ud) << FRAC_BITS;
              unit_div = {unit_res[DATA_W:0], 1'b0};
              job_d    = J_ALFA;
            end
            J_ALFA: begin
              alfa_d   = alfa_v[FRAC_BITS:0];
              unit_req = '{start: 1'b1, op: UNIT_SQRT};
              unit_opa = ((ONE + alfa_v) >> 1) << FRAC_BITS;
              job_d    = J_COS;
            end
            J_COS: begin
              c_d      = unit_res[DATA_W-1:0];
              unit_req = '{start: 1'b1, op: UNIT_SQRT};
              unit_opa = ((ONE - WIDE_W'(alfa_q)) >> 1) << FRAC_BITS;
              job_d    = J_SIN;
            end
            J_SIN: begin
              s_d     = neg ? -$signed(unit_res[DATA_W-1:0]) : $signed(unit_res[DATA_W-1:0]);
              job_d   = J_CC;
              ph_d    = '0;
              state_d = S_MAC;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_MAC: begin
        acc_d = acc_sum;
        ph_d  = ph_q + 2'd1;
        if (ph_q == term_count(job_q)) begin
          ph_d = '0;
          unique case (job_q)
            J_CC: begin
              cc_d  = acc_sum[DATA_W:0];
              job_d = J_SS;
            end
            J_SS: begin
              ss_d  = acc_sum[DATA_W:0];
              job_d = J_SC;
            end
            J_SC: begin
              sc_d  = acc_sum[DATA_W:0];
              job_d = J_LL;
            end
            J_LL: begin
              nll_d  = acc_sat;
              mat_we = 1'b1;
              mat_wa = lin_addr(l_q, l_q);
              mat_wd = acc_sat;
              job_d  = J_KK;
            end
            J_KK: begin
              nkk_d  = acc_sat;
              mat_we = 1'b1;
              mat_wa = lin_addr(k_q, k_q);
              mat_wd = acc_sat;
              job_d  = J_LK;
            end
            J_LK: begin
              mat_we  = 1'b1;
              mat_wa  = lin_addr(l_q, k_q);
              mat_wd  = acc_sat;
              i_d     = '0;
              vmode_d = 1'b0;
              state_d = S_RDX;
            end
            J_WL: begin
              if (vmode_q) begin
                vec_we = 1'b1;
                vec_wa = lin_addr(i_q, l_q);
                vec_wd = acc_sat;
              end else begin
                mat_we = 1'b1;
                mat_wa = sym_addr(i_q, l_q);
                mat_wd = acc_sat;
              end
              job_d = J_WK;
            end
            J_WK: begin
              if (vmode_q) begin
                vec_we = 1'b1;
                vec_wa = lin_addr(i_q, k_q);
                vec_wd = acc_sat;
              end else begin
                mat_we = 1'b1;
                mat_wa = sym_addr(i_q, k_q);
                mat_wd = acc_sat;
              end
              i_d     = i_q + IDX_W'(1);
              state_d = S_RDX;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RDX: begin
        if (i_q == n_eff) begin
          i_d = '0;
          if (vmode_q) begin
            state_d = S_CHECK;
          end else begin
            vmode_d = 1'b1;
          end
        end else if (!vmode_q && (i_q == l_q || i_q == k_q)) begin
          i_d = i_q + IDX_W'(1);
        end else begin
          mat_ra  = sym_addr(i_q, l_q);
          vec_ra  = lin_addr(i_q, l_q);
          x_d     = vmode_q ? vec_rd : mat_rd;
          state_d = S_RDY;
        end
      end

      S_RDY: begin
        mat_ra  = sym_addr(i_q, k_q);
        vec_ra  = lin_addr(i_q, k_q);
        y_d     = vmode_q ? vec_rd : mat_rd;
        job_d   = J_WL;
        ph_d    = '0;
        state_d = S_MAC;
      end

      S_CHECK: begin
        iter_d = iter_q + LIM_W'(1);
        oi_d   = '0;
        oj_d   = '0;
        if (dif <= (DATA_W + 1)'(tol_q)) begin
          conv_d  = 1'b1;
          state_d = S_OUT;
        end else if (iter_d >= lim_q) begin
          conv_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          si_d    = IDX_W'(1);
          sj_d    = '0;
          best_d  = '0;
          state_d = S_SEARCH;
        end
      end

      S_OUT: begin
        mat_ra   = lin_addr(oi_q, oi_q);
        vec_ra   = lin_addr(oj_q - IDX_W'(1), oi_q);
        strobe_d = 1'b1;
        kind_d   = (oj_q != '0);
        pair_d   = oi_q;
        comp_d   = (oj_q == '0) ? '0 : oj_q - IDX_W'(1);
        rval_d   = (oj_q == '0) ? mat_rd : vec_rd;
        last_d   = (oi_q == n_eff - IDX_W'(1)) && (oj_q == n_eff);
        if (oj_q == n_eff) begin
          oj_d = '0;
          oi_d = oi_q + IDX_W'(1);
          if (oi_q == n_eff - IDX_W'(1)) begin
            state_d = S_IDLE;
          end
        end else begin
          oj_d = oj_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      job_q    <= J_RADIUS;
      ph_q     <= '0;
      si_q     <= '0;
      sj_q     <= '0;
      i_q      <= '0;
      l_q      <= '0;
      k_q      <= '0;
      oi_q     <= '0;
      oj_q     <= '0;
      vmode_q  <= 1'b0;
      best_q   <= '0;
      iter_q   <= '0;
      conv_q   <= 1'b0;
      strobe_q <= 1'b0;
      size_q   <= SIZE_RESET;
      tol_q    <= TOL_RESET;
      lim_q    <= LIM_RESET;
    end else begin
      state_q  <= state_d;
      job_q    <= job_d;
      ph_q     <= ph_d;
      si_q     <= si_d;
      sj_q     <= sj_d;
      i_q      <= i_d;
      l_q      <= l_d;
      k_q      <= k_d;
      oi_q     <= oi_d;
      oj_q     <= oj_d;
      vmode_q  <= vmode_d;
      best_q   <= best_d;
      iter_q   <= iter_d;
      conv_q   <= conv_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SIZE_USED:  size_q <= cfg_data_i[IDX_W-1:0];
          CFG_TOLERANCE:  tol_q  <= cfg_data_i[TOL_W-1:0];
          CFG_ITER_LIMIT: lim_q  <= cfg_data_i[LIM_W-1:0];
          default:        size_q <= size_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    all_q  <= all_d;
    akk_q  <= akk_d;
    p_q    <= p_d;
    c_q    <= c_d;
    s_q    <= s_d;
    cc_q   <= cc_d;
    ss_q   <= ss_d;
    sc_q   <= sc_d;
    nll_q  <= nll_d;
    nkk_q  <= nkk_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rad_q  <= rad_d;
    alfa_q <= alfa_d;
    prod_q <= prod_d;
    sub_q  <= term_sub;
    acc_q  <= acc_d;
    kind_q <= kind_d;
    pair_q <= pair_d;
    comp_q <= comp_d;
    rval_q <= rval_d;
    last_q <= last_d;
    if (mat_we) begin
      mat_q[mat_wa] <= mat_wd;
    end
    if (vec_we) begin
      vec_q[vec_wa] <= vec_wd;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign pair_index_o    = pair_q;
  assign component_o     = comp_q;
  assign result_value_o  = rval_q;
  assign converged_o     = conv_q;
  assign last_result_o   = last_q;

endmodule

[design/cje_divsqrt.sv]
// Iterative unit for the integer square root and the unsigned division.
module cje_divsqrt
  import cje_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  unit_req_t         req_i,
  input  logic [WIDE_W-1:0] opa_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [WIDE_W-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(WIDE_W);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(WIDE_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WIDE_W - 1);
  localparam logic [WIDE_W-1:0] BIT_TOP  = WIDE_W'(1) << (WIDE_W - 2);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  unit_op_e          op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WIDE_W-1:0] x_q, x_d;
  logic [WIDE_W-1:0] res_q, res_d;
  logic [WIDE_W-1:0] bit_q, bit_d;
  logic [DIV_W:0]    rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [WIDE_W-1:0] trial;
  logic [DIV_W:0]    rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    res_d  = res_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = res_q + bit_q;
    rem_sh = {rem_q[DIV_W-1:0], x_q[WIDE_W-1]};
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      x_d    = opa_i;
      res_d  = '0;
      bit_d  = BIT_TOP;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (op_q == UNIT_DIV) begin
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = rem_sh - {1'b0, div_q};
          x_d   = {x_q[WIDE_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          x_d   = {x_q[WIDE_W-2:0], 1'b0};
        end
      end else begin
        if (x_q >= trial) begin
          x_d   = x_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == ((op_q == UNIT_DIV) ? DIV_LAST : SQRT_LAST)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= UNIT_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == UNIT_DIV) ? x_q : res_q;

endmodule

[bench/classical_jacobi_eigen_test.sv]
// Self-checking testbench of the classical Jacobi eigen solver: loads, register writes, results.
`timescale 1ns / 100ps

module classical_jacobi_eigen_test;
  import cje_pkg::*;

  localparam int unsigned NMAX = N_DEFAULT;
  localparam int unsigned FB = FRAC_DEFAULT;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam bit KIND_VALUE = 1'b0;
  localparam bit KIND_VECTOR = 1'b1;
  localparam int unsigned STALL_LIMIT = 60000;
  localparam int unsigned ITEM_GOAL = 480;

  typedef longint unsigned u64_t;

  typedef struct {
    bit        kind;
    bit [2:0]  pair;
    bit [2:0]  comp;
    bit [31:0] value;
    bit        conv;
    bit        last;
  } eigen_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [IDX_W-1:0]         row_i = '0;
  logic [IDX_W-1:0]         col_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     final_element_i = 1'b0;
  logic                     result_strobe_o;
  logic                     kind_o;
  logic [IDX_W-1:0]         pair_index_o;
  logic [IDX_W-1:0]         component_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     converged_o;
  logic                     last_result_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;

  classical_jacobi_eigen dut (.*);

  always #4 clk_i = ~clk_i;

  int            matrix_copy[NMAX*NMAX];
  int            vector_copy[NMAX*NMAX];
  bit [2:0]      size_reg = SIZE_RESET;
  bit [30:0]     tol_reg = TOL_RESET;
  bit [4:0]      limit_reg = LIM_RESET;
  eigen_result_t eigen_queue[$];
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   runs_started = 0;
  int unsigned   results_seen = 0;
  int unsigned   stall_cycles = 0;
  bit            gaps_on = 1'b1;

  function automatic int unsigned used_size();
    if (size_reg < 2) return 2;
    if (size_reg > NMAX) return NMAX;
    return size_reg;
  endfunction

  function automatic longint qfloor(longint p);
    if (p >= 0) return p >>> FB;
    return -longint'((u64_t'(-p) + u64_t'(ONE_Q - 1)) >> FB);
  endfunction

  function automatic longint qmul(longint x, longint y);
    return qfloor(x * y);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic u64_t isqrt(u64_t x);
    u64_t res, b;
    res = 0;
    b = u64_t'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint mat_at(int unsigned i, int unsigned j);
    return longint'(matrix_copy[i*NMAX+j]);
  endfunction

  // Applies one rotation about pivot (l, k) and returns the largest diagonal change.
  function automatic longint rotate_pivot(int unsigned n, int unsigned l, int unsigned k);
    longint a_ll, a_kk, p, d, c, s, cc, ss, sc, dif, df, vl, vk;
    u64_t ud, up, radius, alfa;
    bit neg;
    int work[NMAX*NMAX];
    int wl, wk;
    a_ll = mat_at(l, l);
    a_kk = mat_at(k, k);
    p = mat_at(l, k);
    d = a_ll - a_kk;
    ud = u64_t'(d < 0 ? -d : d);
    up = u64_t'(p < 0 ? -p : p);
    radius = isqrt(((ud * ud) >> 2) + up * up);
    alfa = (radius == 0) ? u64_t'(ONE_Q) : (ud << FB) / (u64_t'(2) * radius);
    if (alfa > u64_t'(ONE_Q)) alfa = u64_t'(ONE_Q);
    neg = (d == 0) ? (p < 0) : ((d > 0) != (p > 0));
    c = longint'(isqrt(((u64_t'(ONE_Q) + alfa) >> 1) << FB));
    s = longint'(isqrt(((u64_t'(ONE_Q) - alfa) >> 1) << FB));
    if (neg) s = -s;
    dif = 0;
    foreach (work[i]) work[i] = 0;
    for (int unsigned i = 0; i < n; i++) work[i*NMAX+i] = matrix_copy[i*NMAX+i];
    for (int unsigned i = 0; i < n; i++) begin
      wl = sat32(qmul(c, mat_at(i, l)) + qmul(s, mat_at(i, k)));
      work[i*NMAX+l] = wl;
      work[l*NMAX+i] = wl;
      wk = sat32(qmul(-s, mat_at(i, l)) + qmul(c, mat_at(i, k)));
      work[i*NMAX+k] = wk;
      work[k*NMAX+i] = wk;
    end
    cc = qmul(c, c);
    ss = qmul(s, s);
    sc = qmul(s, c);
    work[l*NMAX+l] = sat32(qmul(cc, a_ll) + qmul(ss, a_kk) + qmul(2 * sc, p));
    work[k*NMAX+k] = sat32(qmul(ss, a_ll) + qmul(cc, a_kk) - qmul(2 * sc, p));
    work[l*NMAX+k] = sat32(-qmul(sc, d) + qmul(cc - ss, p));
    work[k*NMAX+l] = work[l*NMAX+k];
    for (int unsigned i = 0; i < n; i++) begin
      df = mat_at(i, i) - longint'(work[i*NMAX+i]);
      if (df < 0) df = -df;
      if (df > dif) dif = df;
    end
    for (int unsigned i = 0; i < n; i++) begin
      matrix_copy[i*NMAX+l] = work[i*NMAX+l];
      matrix_copy[l*NMAX+i] = work[i*NMAX+l];
      matrix_copy[i*NMAX+k] = work[i*NMAX+k];
      matrix_copy[k*NMAX+i] = work[i*NMAX+k];
    end
    for (int unsigned i = 0; i < n; i++) begin
      vl = longint'(vector_copy[i*NMAX+l]);
      vk = longint'(vector_copy[i*NMAX+k]);
      work[i*NMAX+l] = sat32(qmul(c, vl) + qmul(s, vk));
      work[i*NMAX+k] = sat32(qmul(-s, vl) + qmul(c, vk));
    end
    for (int unsigned i = 0; i < n; i++) begin
      vector_copy[i*NMAX+l] = work[i*NMAX+l];
      vector_copy[i*NMAX+k] = work[i*NMAX+k];
    end
    return dif;
  endfunction

  // Runs the solver on the stored matrix and queues every eigenvalue and vector component.
  function automatic void solve_eigen();
    int unsigned n, l, k, rotations;
    longint best, m, dif;
    bit conv;
    eigen_result_t r;
    n = used_size();
    rotations = 0;
    conv = 1'b0;
    foreach (vector_copy[i]) vector_copy[i] = 0;
    for (int unsigned i = 0; i < n; i++) vector_copy[i*NMAX+i] = int'(ONE_Q);
    forever begin
      best = 0;
      l = 0;
      k = 0;
      for (int unsigned i = 0; i < n; i++)
        for (int unsigned j = 0; j < i; j++) begin
          m = mat_at(i, j);
          if (m < 0) m = -m;
          if (m > best) begin
            best = m;
            l = i;
            k = j;
          end
        end
      if (best == 0) begin
        conv = 1'b1;
        break;
      end
      dif = rotate_pivot(n, l, k);
      rotations = (rotations + 1) & 31;
      if (dif <= longint'(tol_reg)) begin
        conv = 1'b1;
        break;
      end
      if (rotations >= limit_reg) break;
    end
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j <= n; j++) begin
        r.kind = (j == 0) ? KIND_VALUE : KIND_VECTOR;
        r.pair = 3'(i);
        r.comp = (j == 0) ? 3'd0 : 3'(j - 1);
        r.value = (j == 0) ? matrix_copy[i*NMAX+i] : vector_copy[(j-1)*NMAX+i];
        r.conv = conv;
        r.last = (i == n - 1) && (j == n);
        eigen_queue.push_back(r);
      end
  endfunction

  task automatic send_element(input bit [2:0] r, input bit [2:0] c, input bit [31:0] v,
                              input bit fin);
    int unsigned n;
    if (gaps_on && $urandom_range(99) < 9) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    row_i <= r;
    col_i <= c;
    value_i <= v;
    final_element_i <= fin;
    do @(posedge clk_i); while (busy_o);
    n = used_size();
    if (r < n && c < n) begin
      matrix_copy[r*NMAX+c] = v;
      matrix_copy[c*NMAX+r] = v;
      items_sent++;
    end
    if (fin) begin
      runs_started++;
      solve_eigen();
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (eigen_queue.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIZE_USED:  size_reg = data[2:0];
      CFG_TOLERANCE:  tol_reg = data[30:0];
      CFG_ITER_LIMIT: limit_reg = data[4:0];
      default: ;
    endcase
  endtask

  function automatic bit [31:0] rand_value();
    if ($urandom_range(9) < 2) return $urandom;
    return 32'($urandom_range(0, (1 << 28) - 1)) - 32'(1 << 27);
  endfunction

  // Loads the whole lower triangle in random order, the final flag on the last element.
  task automatic load_matrix(input bit with_noise);
    int unsigned n, cnt, a, b;
    bit [2:0] pr[$], pc[$];
    bit [2:0] tr, tc;
    n = used_size();
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j <= i; j++) begin
        pr.push_back(3'(i));
        pc.push_back(3'(j));
      end
    cnt = pr.size();
    for (int unsigned i = 0; i < cnt; i++) begin
      a = $urandom_range(cnt - 1);
      b = $urandom_range(cnt - 1);
      tr = pr[a]; pr[a] = pr[b]; pr[b] = tr;
      tc = pc[a]; pc[a] = pc[b]; pc[b] = tc;
    end
    for (int unsigned i = 0; i < cnt; i++) begin
      if (with_noise && $urandom_range(9) == 0)
        send_element(3'($urandom_range(n, 7)), 3'($urandom_range(7)), $urandom, 1'b0);
      if ($urandom_range(4) == 0)
        send_element(pc[i], pr[i], rand_value(), i == cnt - 1);
      else
        send_element(pr[i], pc[i], rand_value(), i == cnt - 1);
    end
  endtask

  task automatic load_fixed(input bit [31:0] m[NMAX][NMAX]);
    for (int unsigned i = 0; i < NMAX; i++)
      for (int unsigned j = 0; j <= i; j++)
        send_element(3'(i), 3'(j), m[i][j], (i == NMAX - 1) && (j == i));
  endtask

  task automatic test_defaults();
    load_matrix(1'b0);
  endtask

  task automatic test_special_cases();
    bit [31:0] m[NMAX][NMAX];
    // Diagonal matrix: zero pivot, the run stops at once.
    foreach (m[i, j]) m[i][j] = (i == j) ? 32'(i + 1) << FB : 32'd0;
    load_fixed(m);
    // Equal diagonals with a negative pivot.
    foreach (m[i, j]) m[i][j] = (i == j) ? 32'h0100_0000 : 32'd0;
    m[1][0] = 32'hff80_0000;
    load_fixed(m);
    // Field extremes with saturation.
    foreach (m[i, j]) m[i][j] = ((i + j) % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000;
    m[3][3] = 32'd0;
    m[2][1] = 32'hffff_ffff;
    load_fixed(m);
    // Out-of-size and mirrored elements, then a final element that is itself ignored.
    send_element(3'd7, 3'd7, 32'h1234_5678, 1'b0);
    send_element(3'd1, 3'd3, 32'h0040_0000, 1'b0);
    send_element(3'd2, 3'd0, 32'hffc0_0000, 1'b0);
    send_element(3'd5, 3'd2, 32'h0, 1'b1);
  endtask

  task automatic test_registers();
    bit [31:0] sizes[8] = '{2, 3, 0, 1, 5, 6, 7, 4};
    foreach (sizes[i]) begin
      write_reg(CFG_SIZE_USED, sizes[i]);
      case (i % 4)
        0: begin write_reg(CFG_TOLERANCE, 0); write_reg(CFG_ITER_LIMIT, 31); end
        1: begin write_reg(CFG_TOLERANCE, 32'h7fff_ffff); write_reg(CFG_ITER_LIMIT, 1); end
        2: begin write_reg(CFG_TOLERANCE, 32'hffff_ffff); write_reg(CFG_ITER_LIMIT, 0); end
        default: begin write_reg(CFG_TOLERANCE, 17); write_reg(CFG_ITER_LIMIT, 20); end
      endcase
      load_matrix(1'b1);
    end
  endtask

  task automatic test_random();
    while (items_sent < ITEM_GOAL) begin
      gaps_on = !(items_sent > 200 && items_sent < 300);
      if ($urandom_range(5) == 0) begin
        write_reg(CFG_SIZE_USED, $urandom);
        case ($urandom_range(3))
          0: write_reg(CFG_TOLERANCE, 0);
          1: write_reg(CFG_TOLERANCE, $urandom_range(0, 1000));
          2: write_reg(CFG_TOLERANCE, $urandom_range(0, 1 << 20));
          default: write_reg(CFG_TOLERANCE, $urandom);
        endcase
        write_reg(CFG_ITER_LIMIT, $urandom);
      end
      load_matrix(1'b1);
    end
    gaps_on = 1'b1;
  endtask

  function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      results_seen++;
      if (eigen_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h",
                 $time, result_value_o);
        error_count++;
      end else begin
        eigen_result_t e;
        e = eigen_queue.pop_front();
        check_field("kind", e.kind, kind_o);
        check_field("pair_index", e.pair, pair_index_o);
        check_field("component", e.comp, component_o);
        check_field("result_value", e.value, result_value_o);
        check_field("converged", e.conv, converged_o);
        check_field("last_result", e.last, last_result_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_strobe_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, eigen_queue.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_special_cases();
    test_registers();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (eigen_queue.size() != 0) error_count++;
    $display("Loaded %0d elements over %0d runs and checked %0d results.",
             items_sent, runs_started, results_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
